FILE: hw/rtl/sixteen_bit_register_vm_core_unit_macros.svh
// Assertion macros shared by the checker
`ifndef SIXTEEN_BIT_REGISTER_VM_CORE_UNIT_MACROS_SVH
`define SIXTEEN_BIT_REGISTER_VM_CORE_UNIT_MACROS_SVH

// check a property each clock outside reset
`define SVM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check a property each clock, reset included
`define SVM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hw/rtl/svm_pkg.sv
package svm_pkg;

   localparam int NUM_REGS = 8;

   typedef enum logic [7:0] {
      OP_NOP  = 8'd0,  OP_MOV  = 8'd1,  OP_LDI  = 8'd2,  OP_ADD  = 8'd3,
      OP_SUB  = 8'd4,  OP_AND  = 8'd5,  OP_OR   = 8'd6,  OP_XOR  = 8'd7,
      OP_ADDI = 8'd8,  OP_SUBI = 8'd9,  OP_LD8  = 8'd10, OP_ST8  = 8'd11,
      OP_JMP  = 8'd12, OP_JEQ  = 8'd13, OP_JNE  = 8'd14, OP_JLT  = 8'd15,
      OP_JGE  = 8'd16, OP_CALL = 8'd17, OP_RET  = 8'd18, OP_SYS  = 8'd19,
      OP_HALT = 8'd20
   } opcode_type;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_PC_RANGE = 3'd1;
   localparam logic [2:0] ST_LOAD     = 3'd2;
   localparam logic [2:0] ST_STORE    = 3'd3;
   localparam logic [2:0] ST_OVERFLOW = 3'd4;
   localparam logic [2:0] ST_EMPTY    = 3'd5;
   localparam logic [2:0] ST_NO_SYS   = 3'd6;
   localparam logic [2:0] ST_BAD_OP   = 3'd7;

   localparam logic [2:0] REG_ENTRY  = 3'd0;
   localparam logic [2:0] REG_LENGTH = 3'd1;
   localparam logic [2:0] REG_MEMSZ  = 3'd2;
   localparam logic [2:0] REG_CALLS  = 3'd3;
   localparam logic [2:0] REG_SYS    = 3'd4;

   typedef struct packed {
      logic [7:0]  opcode;
      logic [2:0]  reg_first;
      logic [2:0]  reg_second;
      logic [15:0] immediate;
      logic [15:0] branch_target;
      logic [15:0] sys_value;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        halted_now;
      logic [15:0] next_pc;
      logic        reg_written;
      logic [2:0]  reg_index;
      logic [15:0] reg_value;
      logic        mem_written;
      logic [15:0] mem_address;
      logic [7:0]  mem_byte;
      logic        syscall_taken;
      logic [15:0] syscall_number;
   } rsp_type;

   typedef struct packed {
      logic [15:0] entry_point;
      logic [15:0] program_length;
      logic [10:0] memory_size;
      logic [6:0]  max_calls;
      logic        syscall_present;
   } cfg_type;

endpackage

FILE: hw/rtl/sixteen_bit_register_vm_core_unit.sv
// Channel | Direction | Handshake          | Payload
// req     | in        | req_valid/stall    | req_data (req_type)
// rsp     | out       | rsp_valid/stall    | rsp_data (rsp_type)
// csr     | in/out    | psel/penable/pready| paddr, pwdata, prdata
// In the back end each instruction passes an issue state, which starts the
// register and memory read, then a retire state; the next issues after it retires.
// After reset a clearing pass zeroes every data memory address, during which
// no instruction executes (queued ones wait).
// A stalled result holds the back end; the two-entry queue accepts until full.
module sixteen_bit_register_vm_core_unit import svm_pkg::*; #(
   parameter int MEM_DEPTH   = 1024,
   parameter int STACK_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   cfg_type cfg;
   logic    pc_load, q_valid, q_take;
   req_type q_data;

   svm_csr u_csr (
      .clock, .reset, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
      .cfg, .pc_load
   );

   svm_queue u_queue (
      .clock, .reset,
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (req_data),
      .out_valid (q_valid),
      .out_take  (q_take),
      .out_data  (q_data)
   );

   svm_exec #(.MEM_DEPTH(MEM_DEPTH), .STACK_DEPTH(STACK_DEPTH)) u_exec (
      .clock, .reset, .cfg, .pc_load,
      .in_valid  (q_valid),
      .in_take   (q_take),
      .in_data   (q_data),
      .rsp_valid, .rsp_stall, .rsp_data
   );
endmodule

FILE: hw/rtl/svm_ram.sv
module svm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

FILE: hw/rtl/svm_queue.sv
// Two-entry queue between front and back
module svm_queue import svm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_stall,
   input  req_type in_data,
   output logic    out_valid,
   input  logic    out_take,
   output req_type out_data
);
   req_type    slot_ff [2];
   logic       rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_stall  = (count_ff == 2'd2);
   assign push      = in_valid && !in_stall;
   assign out_valid = (count_ff != 2'd0);
   assign pop       = out_valid && out_take;
   assign out_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      rd_ptr_in = rd_ptr_ff ^ pop;
      wr_ptr_in = wr_ptr_ff ^ push;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end
endmodule

FILE: hw/rtl/svm_exec.sv
// Back end: start the memory read on issue, then retire once the output register is free
module svm_exec import svm_pkg::*; #(
   parameter int MEM_DEPTH   = 1024,
   parameter int STACK_DEPTH = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    pc_load,
   input  logic    in_valid,
   output logic    in_take,
   input  req_type in_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);
   localparam int MAW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int SCW = $clog2(STACK_DEPTH + 1);
   localparam int MSW = $clog2(MEM_DEPTH + 1);

   typedef enum logic [1:0] {
      EX_ISSUE  = 2'b01,
      EX_RETIRE = 2'b10
   } ex_state_type;

   ex_state_type  state_ff, state_in;
   req_type       item_ff;
   logic [15:0]   regs_ff [NUM_REGS];
   logic [15:0]   pc_ff, pc_in;
   logic          halt_ff, halt_in;
   logic [SCW-1:0] sp_ff, sp_in;
   logic [MAW:0]  clr_ff;
   logic          out_valid_ff;
   rsp_type       out_ff, res;
   logic          out_free;
   logic          clearing;

   logic [15:0]   a, b, addr, pc1;
   logic [7:0]    mem_rd;
   logic [15:0]   stk_rd;
   logic          mem_we, stk_we;
   logic [MSW-1:0] mem_lim;
   logic [SCW-1:0] call_lim;
   logic          in_mem;

   assign clearing  = !clr_ff[MAW];
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign in_take   = (state_ff == EX_ISSUE) && !clearing && in_valid;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   assign a    = regs_ff[item_ff.reg_first];
   assign b    = regs_ff[item_ff.reg_second];
   assign addr = regs_ff[in_take ? in_data.reg_second : item_ff.reg_second] +
                 (in_take ? in_data.immediate : item_ff.immediate);
   assign pc1  = pc_ff + 16'd1;

   always_comb begin
      mem_lim = (MSW'(cfg.memory_size) < MSW'(MEM_DEPTH)) ? MSW'(cfg.memory_size)
                                                          : MSW'(MEM_DEPTH);
      call_lim = (SCW'(cfg.max_calls) < SCW'(STACK_DEPTH)) ? SCW'(cfg.max_calls)
                                                           : SCW'(STACK_DEPTH);
   end

   logic [15:0] eaddr;
   assign eaddr  = b + item_ff.immediate;
   assign in_mem = {1'b0, eaddr} < 17'(mem_lim);

   always_comb begin
      res         = '0;
      pc_in       = pc_ff;
      halt_in     = halt_ff;
      sp_in       = sp_ff;
      mem_we      = 1'b0;
      stk_we      = 1'b0;
      if (!halt_ff) begin
         if ({1'b0, pc_ff} >= {1'b0, cfg.program_length}) begin
            res.status = ST_PC_RANGE;
         end else begin
            pc_in = pc1;
            unique case (item_ff.opcode)
               OP_NOP: ;
               OP_MOV:  begin res.reg_written = 1'b1; res.reg_value = b; end
               OP_LDI:  begin res.reg_written = 1'b1; res.reg_value = item_ff.immediate; end
               OP_ADD:  begin res.reg_written = 1'b1; res.reg_value = a + b; end
               OP_SUB:  begin res.reg_written = 1'b1; res.reg_value = a - b; end
               OP_AND:  begin res.reg_written = 1'b1; res.reg_value = a & b; end
               OP_OR:   begin res.reg_written = 1'b1; res.reg_value = a | b; end
               OP_XOR:  begin res.reg_written = 1'b1; res.reg_value = a ^ b; end
               OP_ADDI: begin res.reg_written = 1'b1; res.reg_value = a + item_ff.immediate; end
               OP_SUBI: begin res.reg_written = 1'b1; res.reg_value = a - item_ff.immediate; end
               OP_LD8: begin
                  res.mem_address = eaddr;
                  if (!in_mem) begin
                     res.status = ST_LOAD;
                  end else begin
                     res.mem_byte    = mem_rd;
                     res.reg_written = 1'b1;
                     res.reg_value   = {8'd0, mem_rd};
                  end
               end
               OP_ST8: begin
                  res.mem_address = eaddr;
                  if (!in_mem) begin
                     res.status = ST_STORE;
                  end else begin
                     res.mem_byte    = a[7:0];
                     res.mem_written = 1'b1;
                     mem_we          = 1'b1;
                  end
               end
               OP_JMP: pc_in = item_ff.branch_target;
               OP_JEQ: if (a == b) pc_in = item_ff.branch_target;
               OP_JNE: if (a != b) pc_in = item_ff.branch_target;
               OP_JLT: if (a < b) pc_in = item_ff.branch_target;
               OP_JGE: if (a >= b) pc_in = item_ff.branch_target;
               OP_CALL: begin
                  if (sp_ff >= call_lim) begin
                     res.status = ST_OVERFLOW;
                  end else begin
                     stk_we = 1'b1;
                     sp_in  = sp_ff + SCW'(1);
                     pc_in  = item_ff.branch_target;
                  end
               end
               OP_RET: begin
                  if (sp_ff == '0) begin
                     res.status = ST_EMPTY;
                  end else begin
                     sp_in = sp_ff - SCW'(1);
                     pc_in = stk_rd;
                  end
               end
               OP_SYS: begin
                  res.syscall_number = item_ff.immediate;
                  if (!cfg.syscall_present) begin
                     res.status = ST_NO_SYS;
                  end else begin
                     res.syscall_taken = 1'b1;
                     res.reg_written   = 1'b1;
                     res.reg_value     = item_ff.sys_value;
                  end
               end
               OP_HALT: halt_in = 1'b1;
               default: res.status = ST_BAD_OP;
            endcase
            if (res.reg_written) begin
               res.reg_index = (item_ff.opcode == OP_SYS) ? 3'd0 : item_ff.reg_first;
            end
         end
         if (res.status != ST_OK) begin
            halt_in = 1'b1;
         end
      end
      res.halted_now = halt_in;
      res.next_pc    = pc_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         EX_ISSUE:  if (in_take) state_in = EX_RETIRE;
         EX_RETIRE: if (out_free) state_in = EX_ISSUE;
         default:   state_in = EX_ISSUE;
      endcase
   end

   logic retire;
   assign retire = (state_ff == EX_RETIRE) && out_free;

   // Clear pass writes zero; otherwise store at the effective address
   logic [MAW-1:0] mem_wa, mem_ra;
   assign mem_wa = clearing ? clr_ff[MAW-1:0] : eaddr[MAW-1:0];
   assign mem_ra = addr[MAW-1:0];

   svm_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_dmem (
      .clock   (clock),
      .wr_en   (clearing || (retire && mem_we)),
      .wr_addr (mem_wa),
      .wr_data (clearing ? 8'd0 : a[7:0]),
      .rd_addr (mem_ra),
      .rd_data (mem_rd)
   );

   logic [SCW-1:0] sp_rd;
   assign sp_rd = sp_ff - SCW'(1);

   svm_ram #(.WIDTH(16), .DEPTH(STACK_DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (retire && stk_we),
      .wr_addr (sp_ff[SAW-1:0]),
      .wr_data (pc1),
      .rd_addr (sp_rd[SAW-1:0]),
      .rd_data (stk_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= EX_ISSUE;
         pc_ff        <= 16'd0;
         halt_ff      <= 1'b0;
         sp_ff        <= '0;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_REGS; i++) regs_ff[i] <= 16'd0;
      end else begin
         state_ff <= state_in;
         if (clearing) begin
            if (clr_ff[MAW-1:0] == MAW'(MEM_DEPTH - 1)) begin
               clr_ff <= {1'b1, {MAW{1'b0}}};
            end else begin
               clr_ff <= clr_ff + (MAW + 1)'(1);
            end
         end
         if (retire) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         if (pc_load) begin
            pc_ff <= cfg.entry_point;
         end else if (retire) begin
            pc_ff <= pc_in;
         end
         if (retire) begin
            halt_ff <= halt_in;
            sp_ff   <= sp_in;
            if (res.reg_written) regs_ff[res.reg_index] <= res.reg_value;
         end
      end
      if (in_take) item_ff <= in_data;
      if (retire) out_ff <= res;
   end
endmodule

FILE: hw/rtl/svm_csr.sv
// Configuration register file on the APB-style port
module svm_csr import svm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output cfg_type     cfg,
   output logic        pc_load
);
   cfg_type     cfg_ff;
   logic        wr;
   logic [2:0]  idx;
   logic        pc_load_ff, pc_load_in;

   assign pready     = 1'b1;
   assign wr         = psel && penable && pwrite;
   assign idx        = paddr[4:2];
   // load the pc from a registered strobe after the entry write, once the new value is visible
   assign pc_load_in = wr && (idx == REG_ENTRY);
   assign pc_load    = pc_load_ff;
   assign cfg        = cfg_ff;

   always_comb begin
      prdata = 32'd0;
      unique case (idx)
         REG_ENTRY:  prdata = {16'd0, cfg_ff.entry_point};
         REG_LENGTH: prdata = {16'd0, cfg_ff.program_length};
         REG_MEMSZ:  prdata = {21'd0, cfg_ff.memory_size};
         REG_CALLS:  prdata = {25'd0, cfg_ff.max_calls};
         REG_SYS:    prdata = {31'd0, cfg_ff.syscall_present};
         default:    prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.entry_point     <= 16'd0;
         cfg_ff.program_length  <= 16'd1;
         cfg_ff.memory_size     <= 11'd1024;
         cfg_ff.max_calls       <= 7'd64;
         cfg_ff.syscall_present <= 1'b1;
         pc_load_ff             <= 1'b0;
      end else begin
         pc_load_ff <= pc_load_in;
         if (wr) begin
            unique case (idx)
               REG_ENTRY:  cfg_ff.entry_point     <= pwdata[15:0];
               REG_LENGTH: cfg_ff.program_length  <= pwdata[15:0];
               REG_MEMSZ:  cfg_ff.memory_size     <= pwdata[10:0];
               REG_CALLS:  cfg_ff.max_calls       <= pwdata[6:0];
               REG_SYS:    cfg_ff.syscall_present <= pwdata[0];
               default: ;
            endcase
         end
      end
   end
endmodule

FILE: hw/rtl/svm_checker.sv
`include "sixteen_bit_register_vm_core_unit_macros.svh"
module svm_checker import svm_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data,
   input logic    pready
);
   `SVM_ASSERT(a_req_hold, clock, reset, req_valid && req_stall |=> req_valid, "stalled request dropped")
   `SVM_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "stalled result changed")
   `SVM_ASSERT(a_trap_halts, clock, reset, rsp_valid && rsp_data.status != ST_OK |-> rsp_data.halted_now, "trap without halt")
   `SVM_ASSERT(a_no_write_idx, clock, reset, rsp_valid && !rsp_data.reg_written |-> rsp_data.reg_index == 3'd0 && rsp_data.reg_value == 16'd0, "stray register write fields")
   `SVM_ASSERT_ALWAYS(a_pready, clock, pready, "pready low")
endmodule

bind sixteen_bit_register_vm_core_unit svm_checker u_svm_checker (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .rsp_data, .pready
);
